/* rtl/bsp_pkg.sv */
package bsp_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int DATA_W        = 16;
  localparam int SLOT_IDX_W    = 3;

  localparam logic [DATA_W-1:0] CAP_RESET = 16'd4096;

  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef enum logic [1:0] {
    EV_FLUSH      = 2'd0,
    EV_PLACE      = 2'd1,
    EV_REJECT     = 2'd2,
    EV_FRAME_DONE = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REJECT,
    ST_SCAN,
    ST_FLUSH,
    ST_PLACE,
    ST_FRD,
    ST_FCHK,
    ST_FDONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] fill;
  } slot_entry_t;

endpackage

/* rtl/bsp_slot_store.sv */
module bsp_slot_store
  import bsp_pkg::*;
#(
  parameter int  NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int IDX_W     = $clog2(NUM_SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_entry_t      rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_entry_t      wr_data
);

  // Entries not yet written since reset read as the empty slot.
  slot_entry_t            slot_mem [NUM_SLOTS];
  slot_entry_t            rd_q_r;
  logic                   rd_ok_r;
  logic [NUM_SLOTS-1:0]   vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

/* rtl/batch_slot_placement_policy.sv */
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     kind, request_key, request_bytes
// out_      output     out_valid / out_ready   event_res, slot_index, byte_count,
//                                              slot_key, write_offset, last
// cfg_      input      cfg_wr_en               slot_capacity
//
// One transaction is worked on at a time. A place request that fits the slot capacity scans at
// most NUM_SLOTS entries of the slot store, one entry per cycle, and stops early on a key match;
// one larger than the capacity is rejected. A scan's one or two results then follow. An end of
// frame reads each slot in turn, flushes every slot with a non-zero fill, then sends a closing result.
// Reset is synchronous; the slot store needs no clearing pass after it.
// A result waiting in the output register holds the sequencer before its next result.
module batch_slot_placement_policy
  import bsp_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [DATA_W-1:0]     in_request_key,
  input  logic [DATA_W-1:0]     in_request_bytes,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_event_res,
  output logic [SLOT_IDX_W-1:0] out_slot_index,
  output logic [DATA_W-1:0]     out_byte_count,
  output logic [DATA_W-1:0]     out_slot_key,
  output logic [DATA_W-1:0]     out_write_offset,
  output logic                  out_last,
  input  logic                  cfg_wr_en,
  input  logic [DATA_W-1:0]     cfg_wr_data
);

  localparam int               IDX_W    = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_t              state_r, state_nxt;
  logic [DATA_W-1:0]   cap_r;
  logic [DATA_W-1:0]   key_r, key_nxt;
  logic [DATA_W-1:0]   bytes_r, bytes_nxt;
  logic [IDX_W-1:0]    iss_idx_r, iss_idx_nxt;
  logic                iss_done_r, iss_done_nxt;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_tag_r;
  logic [IDX_W-1:0]    sel_idx_r, sel_idx_nxt;
  logic [DATA_W-1:0]   sel_key_r, sel_key_nxt;
  logic [DATA_W-1:0]   sel_fill_r, sel_fill_nxt;
  logic                match_r, match_nxt;
  logic                found_empty_r, found_empty_nxt;
  logic                flush_nxt;

  logic                out_valid_r;
  event_t              ev_r, ev_nxt;
  logic [IDX_W-1:0]    oidx_r, oidx_nxt;
  logic [DATA_W-1:0]   ocnt_r, ocnt_nxt;
  logic [DATA_W-1:0]   okey_r, okey_nxt;
  logic [DATA_W-1:0]   ooff_r, ooff_nxt;
  logic                olast_r, olast_nxt;
  logic                out_load;
  logic                out_free;

  logic                rd_en;
  slot_entry_t         rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  slot_entry_t         wr_data;

  logic                in_acc;
  logic                scan_hit;
  logic                is_match;
  logic                scan_end;
  logic [DATA_W:0]     need_sum;
  logic [DATA_W-1:0]   place_key;

  bsp_slot_store #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (iss_idx_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign scan_hit  = (state_r == ST_SCAN) && rd_vld_r;
  assign is_match  = (rd_data.key == key_r);
  assign scan_end  = scan_hit && (is_match || (rd_tag_r == LAST_IDX));
  assign need_sum  = {1'b0, bytes_r} + {1'b0, rd_data.fill};
  assign place_key = match_r ? sel_key_r : key_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_FRAME) begin
            state_nxt = ST_FRD;
          end else if (in_request_bytes > cap_r) begin
            state_nxt = ST_REJECT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_REJECT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = flush_nxt ? ST_FLUSH : ST_PLACE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FRD: begin
        state_nxt = ST_FCHK;
      end
      ST_FCHK: begin
        if (rd_data.fill == '0 || out_free) begin
          state_nxt = (iss_idx_r == LAST_IDX) ? ST_FDONE : ST_FRD;
        end
      end
      ST_FDONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    key_nxt         = key_r;
    bytes_nxt       = bytes_r;
    iss_idx_nxt     = iss_idx_r;
    iss_done_nxt    = iss_done_r;
    sel_idx_nxt     = sel_idx_r;
    sel_key_nxt     = sel_key_r;
    sel_fill_nxt    = sel_fill_r;
    match_nxt       = match_r;
    found_empty_nxt = found_empty_r;
    flush_nxt       = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = sel_idx_r;
    wr_data         = '{key: place_key, fill: sel_fill_r + bytes_r};
    out_load        = 1'b0;
    ev_nxt          = ev_r;
    oidx_nxt        = oidx_r;
    ocnt_nxt        = ocnt_r;
    okey_nxt        = okey_r;
    ooff_nxt        = ooff_r;
    olast_nxt       = olast_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt         = in_request_key;
          bytes_nxt       = in_request_bytes;
          iss_idx_nxt     = '0;
          iss_done_nxt    = 1'b0;
          match_nxt       = 1'b0;
          found_empty_nxt = 1'b0;
        end
      end
      ST_REJECT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ev_nxt    = EV_REJECT;
          oidx_nxt  = '0;
          ocnt_nxt  = bytes_r;
          okey_nxt  = key_r;
          ooff_nxt  = '0;
          olast_nxt = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!iss_done_r) begin
          rd_en = 1'b1;
          if (iss_idx_r == LAST_IDX) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_idx_nxt = iss_idx_r + 1'b1;
          end
        end
        if (scan_hit) begin
          if (is_match) begin
            match_nxt    = 1'b1;
            sel_idx_nxt  = rd_tag_r;
            sel_key_nxt  = rd_data.key;
            sel_fill_nxt = rd_data.fill;
          end else if (rd_tag_r == '0) begin
            sel_idx_nxt  = rd_tag_r;
            sel_key_nxt  = rd_data.key;
            sel_fill_nxt = rd_data.fill;
          end else if (!found_empty_r &&
                       (rd_data.fill > sel_fill_r || rd_data.fill == '0)) begin
            sel_idx_nxt     = rd_tag_r;
            sel_key_nxt     = rd_data.key;
            sel_fill_nxt    = rd_data.fill;
            found_empty_nxt = (rd_data.fill == '0);
          end
          if (is_match) begin
            flush_nxt = need_sum > {1'b0, cap_r};
          end else begin
            flush_nxt = !found_empty_nxt;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          ev_nxt       = EV_FLUSH;
          oidx_nxt     = sel_idx_r;
          ocnt_nxt     = sel_fill_r;
          okey_nxt     = sel_key_r;
          ooff_nxt     = '0;
          olast_nxt    = 1'b0;
          sel_fill_nxt = '0;
        end
      end
      ST_PLACE: begin
        if (out_free) begin
          out_load  = 1'b1;
          wr_en     = 1'b1;
          ev_nxt    = EV_PLACE;
          oidx_nxt  = sel_idx_r;
          ocnt_nxt  = bytes_r;
          okey_nxt  = place_key;
          ooff_nxt  = sel_fill_r;
          olast_nxt = 1'b1;
        end
      end
      ST_FRD: begin
        rd_en = 1'b1;
      end
      ST_FCHK: begin
        if (rd_data.fill != '0 && out_free) begin
          out_load  = 1'b1;
          wr_en     = 1'b1;
          wr_addr   = iss_idx_r;
          wr_data   = '{key: rd_data.key, fill: '0};
          ev_nxt    = EV_FLUSH;
          oidx_nxt  = iss_idx_r;
          ocnt_nxt  = rd_data.fill;
          okey_nxt  = rd_data.key;
          ooff_nxt  = '0;
          olast_nxt = 1'b0;
        end
        if ((rd_data.fill == '0 || out_free) && iss_idx_r != LAST_IDX) begin
          iss_idx_nxt = iss_idx_r + 1'b1;
        end
      end
      ST_FDONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          ev_nxt    = EV_FRAME_DONE;
          oidx_nxt  = '0;
          ocnt_nxt  = '0;
          okey_nxt  = '0;
          ooff_nxt  = '0;
          olast_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cap_r         <= CAP_RESET;
      iss_done_r    <= 1'b0;
      rd_vld_r      <= 1'b0;
      match_r       <= 1'b0;
      found_empty_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      iss_done_r    <= iss_done_nxt;
      rd_vld_r      <= rd_en;
      match_r       <= match_nxt;
      found_empty_r <= found_empty_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    bytes_r    <= bytes_nxt;
    iss_idx_r  <= iss_idx_nxt;
    rd_tag_r   <= iss_idx_r;
    sel_idx_r  <= sel_idx_nxt;
    sel_key_r  <= sel_key_nxt;
    sel_fill_r <= sel_fill_nxt;
    ev_r       <= ev_nxt;
    oidx_r     <= oidx_nxt;
    ocnt_r     <= ocnt_nxt;
    okey_r     <= okey_nxt;
    ooff_r     <= ooff_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_slot_index   = SLOT_IDX_W'(oidx_r);
  assign out_byte_count   = ocnt_r;
  assign out_slot_key     = okey_r;
  assign out_write_offset = ooff_r;
  assign out_last         = olast_r;

  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> out_load)
    else $error("slot store written without a result transaction");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && olast_nxt) |=> (state_r == ST_IDLE))
    else $error("final result did not return the sequencer to idle");

  a_oversize_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_PLACE && in_request_bytes > cap_r)
      |=> (state_r == ST_REJECT))
    else $error("oversize request not rejected");

  a_empty_victim_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (found_empty_r && !match_r) |-> (sel_fill_r == '0))
    else $error("empty slot chosen with a non-zero fill");

endmodule
